// ----- hdl/edfq_pkg.sv -----
// Shared types and constants of the EDF ready queue scheduler.
package edfq_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int TIME_BITS_DEF = 16;

  localparam int TASK_W     = 3;
  localparam int FIELD_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } edfq_state_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic scan_start;
    logic rd_en;
    logic load_out;
  } edfq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } edfq_sts_t;

endpackage

// ----- hdl/edfq_ctrl.sv -----
// Sequencer for the EDF queue: accept, slot update, head scan, result load.
module edfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  edfq_pkg::edfq_sts_t sts,
  output edfq_pkg::edfq_cmd_t cmd
);
  import edfq_pkg::*;

  edfq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_SCAN:   cmd.rd_en = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_RESULT: cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- hdl/edfq_dp.sv -----
// Datapath of the EDF queue: slot memory, valid bits, head search, counters, output register.
module edfq_dp #(
  parameter int MAX_TASKS = edfq_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = edfq_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  edfq_pkg::edfq_cmd_t               cmd,
  output edfq_pkg::edfq_sts_t               sts,
  input  logic [edfq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [edfq_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import edfq_pkg::*;

  localparam int IW    = $clog2(MAX_TASKS);
  localparam int ENT_W = 2 * TIME_BITS;

  // latched item
  logic                 item_mode_r;
  logic [TASK_W-1:0]    item_tid_r;
  logic [TIME_BITS-1:0] item_dl_r;
  logic [TIME_BITS-1:0] item_ex_r;

  // slot store: {deadline, remaining}
  logic [ENT_W-1:0]     mem [MAX_TASKS];
  logic [ENT_W-1:0]     rd_data_r;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [ENT_W-1:0]     wr_data;

  // head search
  logic [IW-1:0]        cnt_r;
  logic                 cmp_en_r;
  logic [IW-1:0]        cmp_idx_r;
  logic                 best_vld_r;
  logic [IW-1:0]        best_idx_r;
  logic [TIME_BITS-1:0] best_dl_r;
  logic [TIME_BITS-1:0] best_rem_r;
  logic [TIME_BITS-1:0] cand_dl;
  logic                 cand_take;

  // per-item flags and totals
  logic                 completed_r, completed_nxt;
  logic [TASK_W-1:0]    comp_task_r, comp_task_nxt;
  logic                 missed_r, missed_nxt;
  logic [COUNT_W-1:0]   done_r, done_nxt;
  logic [COUNT_W-1:0]   miss_r, miss_nxt;

  logic                 out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [IW-1:0]        slot_idx;
  logic                 tid_ok;

  assign slot_idx = IW'(item_tid_r);
  assign tid_ok   = (32'(item_tid_r) < MAX_TASKS);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_mode_r <= in_tuser;
      item_tid_r  <= in_tdata[TASK_W-1:0];
      item_dl_r   <= TIME_BITS'(in_tdata[TASK_W+FIELD_W-1:TASK_W]);
      item_ex_r   <= TIME_BITS'(in_tdata[TASK_W+2*FIELD_W-1:TASK_W+FIELD_W]);
    end
  end

  // slot update
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = slot_idx;
    wr_data       = {item_dl_r, item_ex_r};
    valid_nxt     = valid_r;
    completed_nxt = completed_r;
    comp_task_nxt = comp_task_r;
    missed_nxt    = missed_r;
    done_nxt      = done_r;
    miss_nxt      = miss_r;
    if (cmd.update) begin
      completed_nxt = 1'b0;
      comp_task_nxt = '0;
      missed_nxt    = 1'b0;
      if (item_mode_r == MODE_RELEASE) begin
        if (tid_ok) begin
          wr_en = 1'b1;
          valid_nxt[slot_idx] = 1'b1;
          if (valid_r[slot_idx]) begin
            missed_nxt = 1'b1;
            if (miss_r != '1) miss_nxt = miss_r + COUNT_W'(1);
          end
        end
      end else if (best_vld_r) begin
        wr_addr = best_idx_r;
        if (best_rem_r > TIME_BITS'(1)) begin
          wr_en   = 1'b1;
          wr_data = {best_dl_r, best_rem_r - TIME_BITS'(1)};
        end else begin
          valid_nxt[best_idx_r] = 1'b0;
          completed_nxt = 1'b1;
          comp_task_nxt = TASK_W'(best_idx_r);
          if (done_r != '1) done_nxt = done_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data_r <= mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      done_r      <= '0;
      miss_r      <= '0;
      completed_r <= 1'b0;
      missed_r    <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      miss_r      <= miss_nxt;
      completed_r <= completed_nxt;
      missed_r    <= missed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comp_task_r <= comp_task_nxt;
  end

  // linear scan, one slot per cycle; strict less-than keeps the lower id on ties
  assign cand_dl   = rd_data_r[ENT_W-1:TIME_BITS];
  assign cand_take = cmp_en_r && valid_r[cmp_idx_r] && (!best_vld_r || cand_dl < best_dl_r);
  assign sts.scan_last = (cnt_r == IW'(MAX_TASKS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cmp_en_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_en;
      if (cmd.scan_start) begin
        cnt_r      <= '0;
        best_vld_r <= 1'b0;
      end else begin
        if (cmd.rd_en) cnt_r <= cnt_r + IW'(1);
        if (cand_take) best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
    if (cand_take && !cmd.scan_start) begin
      best_idx_r <= cmp_idx_r;
      best_dl_r  <= cand_dl;
      best_rem_r <= rd_data_r[TIME_BITS-1:0];
    end
  end

  // output register
  assign sts.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'b0, miss_r, done_r, missed_r, comp_task_r, completed_r,
                     best_vld_r ? TASK_W'(best_idx_r) : {TASK_W{1'b0}}, best_vld_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hdl/edf_ready_queue_scheduler_top.sv -----
// Top level of the EDF ready queue scheduler.
// An accepted item passes the states UPDATE, SCAN, DRAIN and RESULT before out_tvalid rises.
// A new item is accepted only after the result is loaded, so while results are taken at once the rate is
// set by the head search, which reads the slot memory one slot per cycle.
// A new item is taken while the previous result still waits in the output register.
// Synchronous active-low reset empties the queue and clears both totals.
module edf_ready_queue_scheduler_top #(
  parameter int MAX_TASKS = edfq_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = edfq_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // task_id[2:0], abs_deadline[18:3], exec_time[34:19], zero fill
  input  logic [edfq_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // running_valid[0], running_task[3:1], completed[4], completed_task[7:5],
  // missed[8], done_total[24:9], miss_total[40:25], zero fill
  output logic [edfq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import edfq_pkg::*;

  edfq_cmd_t cmd;
  edfq_sts_t sts;

  edfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edfq_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hdl/edfq_chk.sv -----
// Port-level checker for the EDF ready queue scheduler, with its bind.
module edfq_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [edfq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import edfq_pkg::*;

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] || out_tdata[3:1] == 3'd0)
    else $error("running task set with empty queue");

  // a tick never misses and a release never completes
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[8]) &&
                   (out_tdata[4] || out_tdata[7:5] == 3'd0))
    else $error("inconsistent completion or miss flags");

endmodule

bind edf_ready_queue_scheduler_top edfq_chk u_edfq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
